FILE: hdl/crc16_frame_encoder_assert.svh
// assertion macros shared by the frame encoder
`ifndef CRC16_FRAME_ENCODER_ASSERT_SVH
`define CRC16_FRAME_ENCODER_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/crc16fe_pkg.sv
package crc16fe_pkg;

  // frame geometry
  localparam int unsigned MaxPayload  = 512;
  localparam int unsigned HeaderBytes = 9;
  localparam int unsigned CrcBytes    = 2;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // input function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MAGIC_FIRST    = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND   = 2'd1;
  localparam logic [1:0] REG_VERSION_BYTE   = 2'd2;
  localparam logic [1:0] REG_FRAME_CAPACITY = 2'd3;

  localparam logic [16:0] CAPACITY_RESET = 17'd65546;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_OVER_CAP = 2'd2,
    STATUS_STRAY    = 2'd3
  } status_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  flags;
    logic [7:0]  command;
    logic [15:0] sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    status_e    status;
  } out_t;

  // one byte through the reflected crc
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/crc16_frame_encoder.sv
// an accepted transaction goes into the item register, then its first result byte into
// the output register; a payload byte yields one result byte, the last one also the two
// crc bytes, a start the nine header bytes (plus the crc with an empty payload), an
// error one byte; the byte sequencer emits one byte per cycle unless the output stalls
// reset: asynchronous active low; crc to 0xFFFF, no frame open, registers to defaults
module crc16_frame_encoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [16:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  crc16fe_pkg::in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output crc16fe_pkg::out_t    out_data_o
);

  // byte sequencer step codes
  localparam logic [3:0] STEP_FIRST    = 4'd0;
  localparam logic [3:0] STEP_LAST_HDR = 4'd8;
  localparam logic [3:0] STEP_CRC_LO   = 4'd9;
  localparam logic [3:0] STEP_CRC_HI   = 4'd10;

  localparam logic [15:0] MAX_LEN   = 16'(crc16fe_pkg::MaxPayload);
  localparam logic [16:0] FRAME_OVH = 17'(crc16fe_pkg::HeaderBytes + crc16fe_pkg::CrcBytes);

  // configuration registers
  logic [7:0]  magic_first_q, magic_second_q, version_byte_q;
  logic [16:0] frame_capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_first_q    <= '0;
      magic_second_q   <= '0;
      version_byte_q   <= '0;
      frame_capacity_q <= crc16fe_pkg::CAPACITY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crc16fe_pkg::REG_MAGIC_FIRST:    magic_first_q    <= cfg_data_i[7:0];
        crc16fe_pkg::REG_MAGIC_SECOND:   magic_second_q   <= cfg_data_i[7:0];
        crc16fe_pkg::REG_VERSION_BYTE:   version_byte_q   <= cfg_data_i[7:0];
        crc16fe_pkg::REG_FRAME_CAPACITY: frame_capacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item register and frame state
  crc16fe_pkg::in_t  item_q;
  logic              active_q, active_d;
  logic [3:0]        step_q, step_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       rem_q, rem_d;
  logic              open_q, open_d;
  crc16fe_pkg::out_t out_q, res_d;
  logic              out_valid_q, out_valid_d;

  logic        fire, last, accept;
  logic [7:0]  hdr_byte;
  logic [15:0] crc_in;
  logic [16:0] total;
  logic        too_long, over_cap;

  // emitter moves one byte into the output register when it has room
  assign fire       = active_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = active_q && !(fire && last);
  assign accept     = in_valid_i && !in_stall_o;

  assign total    = {1'b0, item_q.payload_length} + FRAME_OVH;
  assign too_long = item_q.payload_length > MAX_LEN;
  assign over_cap = total > frame_capacity_q;
  assign crc_in   = (step_q == STEP_FIRST) ? crc16fe_pkg::CRC_INIT : crc_q;

  // header byte for the current step
  always_comb begin
    case (step_q)
      4'd0:    hdr_byte = magic_first_q;
      4'd1:    hdr_byte = magic_second_q;
      4'd2:    hdr_byte = version_byte_q;
      4'd3:    hdr_byte = item_q.flags;
      4'd4:    hdr_byte = item_q.command;
      4'd5:    hdr_byte = item_q.sequence_req[7:0];
      4'd6:    hdr_byte = item_q.sequence_req[15:8];
      4'd7:    hdr_byte = item_q.payload_length[7:0];
      4'd8:    hdr_byte = item_q.payload_length[15:8];
      default: hdr_byte = '0;
    endcase
  end

  // result byte and next frame state for the current step
  always_comb begin
    res_d.out_byte  = '0;
    res_d.frame_end = 1'b0;
    res_d.status    = crc16fe_pkg::STATUS_OK;
    last            = 1'b0;
    step_d          = step_q + 4'd1;
    crc_d           = crc_q;
    rem_d           = rem_q;
    open_d          = open_q;
    if (step_q == STEP_CRC_LO) begin
      res_d.out_byte = crc_q[7:0];
    end else if (step_q == STEP_CRC_HI) begin
      res_d.out_byte  = crc_q[15:8];
      res_d.frame_end = 1'b1;
      last            = 1'b1;
      crc_d           = crc16fe_pkg::CRC_INIT;
      rem_d           = '0;
      open_d          = 1'b0;
    end else if (item_q.func == crc16fe_pkg::FUNC_START) begin
      // a start abandons any open frame
      if (step_q == STEP_FIRST) begin
        open_d = 1'b0;
        rem_d  = '0;
        crc_d  = crc16fe_pkg::CRC_INIT;
      end
      if (step_q == STEP_FIRST && too_long) begin
        res_d.frame_end = 1'b1;
        res_d.status    = crc16fe_pkg::STATUS_TOO_LONG;
        last            = 1'b1;
      end else if (step_q == STEP_FIRST && over_cap) begin
        res_d.frame_end = 1'b1;
        res_d.status    = crc16fe_pkg::STATUS_OVER_CAP;
        last            = 1'b1;
      end else begin
        res_d.out_byte = hdr_byte;
        crc_d          = crc16fe_pkg::crc_byte(crc_in, hdr_byte);
        if (step_q == STEP_LAST_HDR) begin
          if (item_q.payload_length == '0) begin
            step_d = STEP_CRC_LO;
          end else begin
            last   = 1'b1;
            open_d = 1'b1;
            rem_d  = item_q.payload_length;
          end
        end
      end
    end else begin
      // payload byte: pass through, or flag it when no frame is open
      if (!open_q) begin
        res_d.frame_end = 1'b1;
        res_d.status    = crc16fe_pkg::STATUS_STRAY;
        last            = 1'b1;
      end else begin
        res_d.out_byte = item_q.payload_byte;
        crc_d          = crc16fe_pkg::crc_byte(crc_q, item_q.payload_byte);
        rem_d          = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          step_d = STEP_CRC_LO;
        end else begin
          last = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (accept) begin
      active_d = 1'b1;
    end else if (fire && last) begin
      active_d = 1'b0;
    end else begin
      active_d = active_q;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= STEP_FIRST;
      crc_q       <= crc16fe_pkg::CRC_INIT;
      rem_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        crc_q  <= crc_d;
        rem_q  <= rem_d;
        open_q <= open_d;
      end
      if (accept || (fire && last)) begin
        step_q <= STEP_FIRST;
      end else if (fire) begin
        step_q <= step_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "crc16_frame_encoder_assert.svh"

  // error results carry a zero byte and close the frame
  `ASSERT_CLK(a_err_ends, out_valid_o && out_data_o.status != crc16fe_pkg::STATUS_OK |-> out_data_o.frame_end && out_data_o.out_byte == 8'd0, "error result without frame end")
  // an open frame has bytes left to come until its trailer starts
  `ASSERT_NEVER(a_open_rem, open_q && rem_q == 16'd0 && step_q < STEP_CRC_LO, "open frame empty")
  // an accepted transaction starts the sequencer at its first step
  `ASSERT_CLK(a_accept_start, accept |=> active_q && step_q == STEP_FIRST, "accepted item not started")
  // the sequencer never runs past the last crc byte
  `ASSERT_NEVER(a_step_range, active_q && step_q > STEP_CRC_HI, "sequencer step out of range")

endmodule

FILE: tb/crc16_frame_checker.sv
`timescale 1ns / 1ps

module crc16_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  crc16fe_pkg::in_t   in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  crc16fe_pkg::out_t  out_data_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  import crc16fe_pkg::*;

  // register copies
  logic [7:0]  magic_a;
  logic [7:0]  magic_b;
  logic [7:0]  version_q;
  logic [16:0] capacity_q;

  // frame state of the encoder
  logic [15:0] crc_acc;
  logic [15:0] bytes_left;
  logic        frame_active;

  out_t        frame_bytes_q[$];
  int          mismatch_cnt = 0;

  assign fail_count_o = mismatch_cnt;

  // bitwise reflected crc, data bits folded in as they reach bit 0
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                  input logic [7:0] data);
    logic [15:0] acc;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ data[i]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("%0t: encoder mismatch: %s", $time, what);
  endtask

  task automatic push_result(input logic [7:0] data, input logic last, input status_e st);
    out_t res;
    res.out_byte  = data;
    res.frame_end = last;
    res.status    = st;
    frame_bytes_q.push_back(res);
  endtask

  task automatic emit_frame_byte(input logic [7:0] data);
    crc_acc = modbus_crc_step(crc_acc, data);
    push_result(data, 1'b0, STATUS_OK);
  endtask

  // crc low byte then high byte, frame closes
  task automatic emit_crc_trailer();
    push_result(crc_acc[7:0], 1'b0, STATUS_OK);
    push_result(crc_acc[15:8], 1'b1, STATUS_OK);
    crc_acc      = CRC_INIT;
    bytes_left   = '0;
    frame_active = 1'b0;
  endtask

  // expected frame bytes for one accepted input transaction
  task automatic predict_frame(input in_t item);
    int unsigned frame_total;
    frame_total = HeaderBytes + item.payload_length + CrcBytes;
    if (item.func == FUNC_START) begin
      // a start always drops any open frame
      crc_acc      = CRC_INIT;
      bytes_left   = '0;
      frame_active = 1'b0;
      if (item.payload_length > MaxPayload) begin
        push_result(8'h00, 1'b1, STATUS_TOO_LONG);
      end else if (frame_total > capacity_q) begin
        push_result(8'h00, 1'b1, STATUS_OVER_CAP);
      end else begin
        emit_frame_byte(magic_a);
        emit_frame_byte(magic_b);
        emit_frame_byte(version_q);
        emit_frame_byte(item.flags);
        emit_frame_byte(item.command);
        emit_frame_byte(item.sequence_req[7:0]);
        emit_frame_byte(item.sequence_req[15:8]);
        emit_frame_byte(item.payload_length[7:0]);
        emit_frame_byte(item.payload_length[15:8]);
        if (item.payload_length == 16'd0) begin
          emit_crc_trailer();
        end else begin
          bytes_left   = item.payload_length;
          frame_active = 1'b1;
        end
      end
    end else if (!frame_active) begin
      push_result(8'h00, 1'b1, STATUS_STRAY);
    end else begin
      emit_frame_byte(item.payload_byte);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
        emit_crc_trailer();
      end
    end
  endtask

  // compare one output transaction with the oldest expected byte
  task automatic check_result(input out_t got);
    out_t want;
    if (frame_bytes_q.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h end %0b status %0d",
                                got.out_byte, got.frame_end, got.status));
    end else begin
      want = frame_bytes_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      end
      if (got.frame_end !== want.frame_end) begin
        report_mismatch($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
      end
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      end
    end
  endtask

  // watch config, input and output channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_a      = '0;
      magic_b      = '0;
      version_q    = '0;
      capacity_q   = CAPACITY_RESET;
      crc_acc      = CRC_INIT;
      bytes_left   = '0;
      frame_active = 1'b0;
      frame_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAGIC_FIRST:    magic_a    = cfg_data_i[7:0];
          REG_MAGIC_SECOND:   magic_b    = cfg_data_i[7:0];
          REG_VERSION_BYTE:   version_q  = cfg_data_i[7:0];
          REG_FRAME_CAPACITY: capacity_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_frame(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
      pending_o <= frame_bytes_q.size();
    end
  end

endmodule

FILE: tb/tb_crc16_frame_encoder.sv
`timescale 1ns / 1ps

module tb_crc16_frame_encoder;
  import crc16fe_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [16:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  int          fail_count;
  int          pending_cnt;
  logic        no_idle     = 1'b0;
  int          sent_cnt    = 0;
  logic [16:0] cap_now     = CAPACITY_RESET;

  crc16_frame_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  crc16_frame_checker frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .pending_o    (pending_cnt),
    .fail_count_o (fail_count)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // hard stop if the encoder hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 13);
  end

  // one input transaction, with an occasional idle gap in front
  task automatic send_txn(input in_t item);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent_cnt++;
  endtask

  task automatic send_start(input logic [7:0] flags, input logic [7:0] cmd,
                            input logic [15:0] seq, input logic [15:0] len);
    in_t item;
    item.func           = FUNC_START;
    item.flags          = flags;
    item.command        = cmd;
    item.sequence_req   = seq;
    item.payload_length = len;
    item.payload_byte   = 8'($urandom());
    send_txn(item);
  endtask

  task automatic send_payload(input logic [7:0] data);
    in_t item;
    item.func           = FUNC_PAYLOAD;
    item.flags          = 8'($urandom());
    item.command        = 8'($urandom());
    item.sequence_req   = 16'($urandom());
    item.payload_length = 16'($urandom());
    item.payload_byte   = data;
    send_txn(item);
  endtask

  // hold off the sender until every expected byte is out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [7:0] m_first, input logic [7:0] m_second,
                             input logic [7:0] ver, input logic [16:0] cap);
    write_reg(REG_MAGIC_FIRST, {9'd0, m_first});
    write_reg(REG_MAGIC_SECOND, {9'd0, m_second});
    write_reg(REG_VERSION_BYTE, {9'd0, ver});
    write_reg(REG_FRAME_CAPACITY, cap);
    cfg_we_i <= 1'b0;
    cap_now = cap;
  endtask

  // mostly whole frames with random content, some errors and noise
  task automatic random_phase(input int n_items);
    int stop_at;
    int pick;
    int len;
    int cut;
    int limit;
    stop_at = sent_cnt + n_items;
    limit   = (cap_now > HeaderBytes + CrcBytes) ? cap_now - HeaderBytes - CrcBytes : 0;
    if (limit > MaxPayload) limit = MaxPayload;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        if (len > limit) len = limit;
        // now and then break the frame off so the next start abandons it
        cut = ($urandom_range(19) == 0 && len > 1) ? $urandom_range(1, len - 1) : len;
        send_start(8'($urandom()), 8'($urandom()), 16'($urandom()), 16'(len));
        for (int i = 0; i < cut; i++) send_payload(8'($urandom()));
      end else if (pick < 86) begin
        send_start(8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()));
      end else if (pick < 92) begin
        send_payload(8'($urandom()));
      end else if (pick < 97) begin
        // right at the payload limit or one byte past it
        len = limit + $urandom_range(0, 1);
        send_start(8'($urandom()), 8'($urandom()), 16'($urandom()), 16'(len));
        if (len <= limit) begin
          for (int i = 0; i < len && i < 16; i++) send_payload(8'($urandom()));
        end
      end else begin
        drain();
      end
    end
    // leave no frame open across a register update
    send_start(8'($urandom()), 8'($urandom()), 16'($urandom()), 16'd0);
  endtask

  // stimulus and verdict
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    send_start(8'hFF, 8'h00, 16'hFFFF, 16'd0);
    send_start(8'h00, 8'hFF, 16'h0000, 16'd1);
    send_payload(8'hFF);
    send_payload(8'h00);
    send_start(8'h12, 8'h34, 16'h5678, 16'd513);
    send_start(8'h9A, 8'hBC, 16'hDEF0, 16'hFFFF);
    send_start(8'h01, 8'h02, 16'h1234, 16'd512);
    send_payload(8'h5A);
    send_start(8'h03, 8'h04, 16'h4321, 16'd2);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    send_start(8'hA5, 8'h5A, 16'h8001, 16'd3);
    send_payload(8'h01);
    send_payload(8'h02);
    send_start(8'h7E, 8'h81, 16'h00FF, 16'd0);
    drain();

    // zero capacity: every start is refused, length test first
    load_config(8'hFF, 8'hFF, 8'hFF, 17'd0);
    send_start(8'h11, 8'h22, 16'h3344, 16'd0);
    send_start(8'h11, 8'h22, 16'h3344, 16'd513);
    send_start(8'h11, 8'h22, 16'h3344, 16'd512);
    send_payload(8'h80);
    drain();

    // capacity exactly one empty frame
    load_config(8'h55, 8'hAA, 8'h01, 17'd11);
    send_start(8'hC3, 8'h3C, 16'hAAAA, 16'd0);
    send_start(8'hC3, 8'h3C, 16'h5555, 16'd1);
    drain();

    // capacity exactly one full-length frame
    load_config(8'h00, 8'hFF, 8'h80, 17'd523);
    send_start(8'h0F, 8'hF0, 16'h0102, 16'd512);
    send_payload(8'h33);
    send_payload(8'hCC);
    send_start(8'hF0, 8'h0F, 16'h0201, 16'd0);
    drain();

    // random traffic over several register settings
    load_config(8'($urandom()), 8'($urandom()), 8'($urandom()), 17'h1FFFF);
    random_phase(125);
    drain();

    load_config(8'($urandom()), 8'($urandom()), 8'($urandom()),
                17'($urandom_range(11, 40)));
    random_phase(125);
    drain();

    load_config(8'($urandom()), 8'($urandom()), 8'($urandom()), CAPACITY_RESET);
    no_idle <= 1'b1;
    random_phase(60);
    no_idle <= 1'b0;
    random_phase(60);
    drain();

    // let any late bytes show up
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
